/* src/rpwh_pkg.sv */
`timescale 1ns / 1ps
// ============================================================================
// rpwh_pkg: shared types and constants of the rolling polynomial window hash
// Field widths, configuration register indexes and the link between cells.
// ============================================================================
package rpwh_pkg;

    localparam int HASH_W    = 32;
    localparam int BYTE_W    = 8;
    localparam int DIGIT_W   = 8;
    localparam int NUM_CELLS = HASH_W / DIGIT_W;
    localparam int CFG_LEN_W = 13;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_LEN_W-1:0] LEN_RESET  = 13'd1024;
    localparam logic [HASH_W-1:0]    BASE_RESET = 32'd31;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW_LENGTH = 1'b0,
        CFG_HASH_BASE     = 1'b1
    } cfg_index_t;

    // Data handed from one multiply-accumulate cell to the next
    typedef struct packed {
        logic [HASH_W-1:0] acc;
        logic [HASH_W-1:0] mult;
    } mac_link_t;

endpackage

/* src/rpwh_stream_if.sv */
`timescale 1ns / 1ps
// ============================================================================
// rpwh_stream_if: valid/ready channels of the rolling hash
// One interface for the byte stream in, one for the hash results out.
// ============================================================================
interface rpwh_byte_if
    import rpwh_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              restart;

    modport source (output valid, output data_byte, output restart, input ready);
    modport sink   (input valid, input data_byte, input restart, output ready);
endinterface

interface rpwh_hash_if
    import rpwh_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [HASH_W-1:0] hash_value;
    logic              window_full;

    modport source (output valid, output hash_value, output window_full, input ready);
    modport sink   (input valid, input hash_value, input window_full, output ready);
endinterface

/* src/rpwh_mac_cell.sv */
`timescale 1ns / 1ps
// ============================================================================
// rpwh_mac_cell: one digit cell of the hash multiply chain
// Add multiplicand times one base digit, pass the shifted multiplicand on.
// ============================================================================
module rpwh_mac_cell
    import rpwh_pkg::*;
(
    input  mac_link_t          link_prev,
    input  logic [DIGIT_W-1:0] digit,
    output mac_link_t          link_next
);

    logic [HASH_W-1:0] product;

    // Keep only the low word: the hash wraps modulo 2^32
    assign product        = link_prev.mult * {{(HASH_W-DIGIT_W){1'b0}}, digit};
    assign link_next.acc  = link_prev.acc + product;
    assign link_next.mult = link_prev.mult << DIGIT_W;

endmodule

/* src/rpwh_window_ram.sv */
`timescale 1ns / 1ps
// ============================================================================
// rpwh_window_ram: ring buffer storage of the window bytes
// Single port, read-first, registered read data.
// ============================================================================
module rpwh_window_ram
    import rpwh_pkg::*;
#(
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = 12
)
(
    input  logic              clk,
    input  logic              en,
    input  logic [ADDR_W-1:0] addr,
    input  logic [BYTE_W-1:0] wdata,
    output logic [BYTE_W-1:0] rdata
);

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] rdata_reg;

    // Read the old byte and overwrite it in the same cycle
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rdata_reg  <= mem[addr];
            mem[addr]  <= wdata;
        end
    end

    assign rdata = rdata_reg;

endmodule

/* src/rolling_polynomial_window_hash.sv */
// Pipeline: an accepted byte passes the stage 1 and 2 registers to the output.
// Throughput: one byte per cycle while the output is not stalled; the hash
// recurrence closes in the digit cells; the memory port is used once per byte.
// Reset: asynchronous, active low; control state and the hash clear at once,
// no clearing pass; window bytes are valid only once written in this window.
`timescale 1ns / 1ps
// ============================================================================
// rolling_polynomial_window_hash: 32-bit polynomial rolling hash over a window
// Keeps a hash of the last window_length bytes, wrapping modulo 2^32.
// ============================================================================
module rolling_polynomial_window_hash
    import rpwh_pkg::*;
#(
    parameter int WINDOW_MAX = 4096
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [HASH_W-1:0]    cfg_data,
    rpwh_byte_if.sink            byte_stream,
    rpwh_hash_if.source          hash_stream
);

    // Fill count holds the length itself; pointer indexes the ring
    localparam int LW   = $clog2(WINDOW_MAX + 1);
    localparam int AW   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CMPW = (LW > CFG_LEN_W) ? LW : CFG_LEN_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [CFG_LEN_W-1:0] len_cfg_reg;
    logic [HASH_W-1:0]    base_reg;
    logic [LW-1:0]        len_eff;

    // Clamp the length into 1..WINDOW_MAX
    always_comb
    begin
        if (len_cfg_reg == '0)
        begin
            len_eff = LW'(1);
        end
        else if (CMPW'(len_cfg_reg) > CMPW'(WINDOW_MAX))
        begin
            len_eff = LW'(WINDOW_MAX);
        end
        else
        begin
            len_eff = LW'(CMPW'(len_cfg_reg));
        end
    end

    // ------------------------------------------------------------------
    // Pipeline flow control: each stage moves when the one after it is
    // empty or moving, so bubbles collapse; while a result waits at the
    // output, the input keeps flowing until stages 1 and 2 are full.
    // ------------------------------------------------------------------
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic out_valid_reg;
    logic out_load;
    logic s2_load;
    logic s1_load;
    logic in_accept;

    assign out_load  = !out_valid_reg || hash_stream.ready;
    assign s2_load   = !s2_valid_reg || out_load;
    assign s1_load   = !s1_valid_reg || s2_load;
    assign in_accept = byte_stream.valid && s1_load;

    assign byte_stream.ready = s1_load;

    // ------------------------------------------------------------------
    // Front end: ring pointer, fill count and base power, updated in the
    // cycle a byte transaction is accepted.
    // ------------------------------------------------------------------
    logic [AW-1:0]     wp_reg;
    logic [AW-1:0]     wp_next;
    logic [LW-1:0]     fill_reg;
    logic [LW-1:0]     fill_next;
    logic [HASH_W-1:0] pow_reg;
    logic [HASH_W-1:0] pow_next;

    logic [AW-1:0]     wp_base;
    logic [LW-1:0]     fill_base;
    logic [HASH_W-1:0] pow_base;
    logic [HASH_W-1:0] pow_prod;
    logic [AW-1:0]     slot;
    logic [LW:0]       slot_inc;
    logic              is_full;
    logic              full_after;

    always_comb
    begin
        // A restart begins a new window with this byte first
        wp_base   = byte_stream.restart ? '0 : wp_reg;
        fill_base = byte_stream.restart ? '0 : fill_reg;
        pow_base  = byte_stream.restart ? HASH_W'(1) : pow_reg;

        slot = ((LW+1)'(wp_base) >= (LW+1)'(len_eff)) ? '0 : wp_base;

        slot_inc = (LW+1)'(slot) + (LW+1)'(1);
        wp_next  = (slot_inc >= (LW+1)'(len_eff)) ? '0 : AW'(slot_inc);

        is_full  = (fill_base >= len_eff);
        pow_prod = pow_base * base_reg;

        // While filling, grow the count and the power; once full, hold both
        fill_next  = is_full ? fill_base : fill_base + LW'(1);
        pow_next   = is_full ? pow_base : pow_prod;
        full_after = (fill_next >= len_eff);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_cfg_reg <= LEN_RESET;
            base_reg    <= BASE_RESET;
            wp_reg      <= '0;
            fill_reg    <= '0;
            pow_reg     <= HASH_W'(1);
        end
        else if (cfg_we)
        begin
            // Any register write restarts the window
            case (cfg_index)
                CFG_WINDOW_LENGTH: len_cfg_reg <= cfg_data[CFG_LEN_W-1:0];
                CFG_HASH_BASE:     base_reg    <= cfg_data;
                default:           len_cfg_reg <= len_cfg_reg;
            endcase
            wp_reg   <= '0;
            fill_reg <= '0;
            pow_reg  <= HASH_W'(1);
        end
        else if (in_accept)
        begin
            wp_reg   <= wp_next;
            fill_reg <= fill_next;
            pow_reg  <= pow_next;
        end
    end

    // Window store: read the oldest byte and write the new one at the slot
    logic [BYTE_W-1:0] oldest_byte;

    rpwh_window_ram #(
        .DEPTH  (WINDOW_MAX),
        .ADDR_W (AW)
    ) u_window_ram (
        .clk   (clk),
        .en    (in_accept),
        .addr  (slot),
        .wdata (byte_stream.data_byte),
        .rdata (oldest_byte)
    );

    // ------------------------------------------------------------------
    // Stage 1: byte and window state captured at acceptance
    // ------------------------------------------------------------------
    logic [BYTE_W-1:0] s1_byte_reg;
    logic              s1_roll_reg;
    logic              s1_restart_reg;
    logic              s1_wfull_reg;
    logic [HASH_W-1:0] s1_pow_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_load)
        begin
            s1_valid_reg <= byte_stream.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_byte_reg    <= byte_stream.data_byte;
            s1_roll_reg    <= is_full;
            s1_restart_reg <= byte_stream.restart;
            s1_wfull_reg   <= full_after;
            s1_pow_reg     <= pow_base;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: correction, new byte; once full, minus oldest byte times base^L
    // ------------------------------------------------------------------
    logic [HASH_W-1:0] new_sext;
    logic [HASH_W-1:0] old_sext;
    logic [HASH_W-1:0] old_term;
    logic [HASH_W-1:0] corr;
    logic [HASH_W-1:0] s2_corr_reg;
    logic              s2_restart_reg;
    logic              s2_wfull_reg;

    assign new_sext = {{(HASH_W-BYTE_W){s1_byte_reg[BYTE_W-1]}}, s1_byte_reg};
    assign old_sext = {{(HASH_W-BYTE_W){oldest_byte[BYTE_W-1]}}, oldest_byte};
    assign old_term = old_sext * s1_pow_reg;
    assign corr     = s1_roll_reg ? (new_sext - old_term) : new_sext;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_load)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_load && s1_valid_reg)
        begin
            s2_corr_reg    <= corr;
            s2_restart_reg <= s1_restart_reg;
            s2_wfull_reg   <= s1_wfull_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: hash * base + correction through the row of digit cells.
    // Each cell adds the hash times one byte of the base and hands the
    // running sum and the shifted hash to its neighbor.
    // ------------------------------------------------------------------
    logic [HASH_W-1:0] hash_reg;
    logic              wfull_reg;
    mac_link_t         chain [NUM_CELLS+1];

    assign chain[0].acc  = s2_corr_reg;
    assign chain[0].mult = s2_restart_reg ? '0 : hash_reg;

    for (genvar k = 0; k < NUM_CELLS; k++)
    begin : g_cell
        rpwh_mac_cell u_cell (
            .link_prev (chain[k]),
            .digit     (base_reg[k*DIGIT_W +: DIGIT_W]),
            .link_next (chain[k+1])
        );
    end

    // The output register is also the running hash state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            hash_reg      <= '0;
            wfull_reg     <= 1'b0;
        end
        else if (cfg_we)
        begin
            hash_reg <= '0;
        end
        else if (out_load)
        begin
            out_valid_reg <= s2_valid_reg;
            if (s2_valid_reg)
            begin
                hash_reg  <= chain[NUM_CELLS].acc;
                wfull_reg <= s2_wfull_reg;
            end
        end
    end

    assign hash_stream.valid       = out_valid_reg;
    assign hash_stream.hash_value  = hash_reg;
    assign hash_stream.window_full = wfull_reg;

`ifndef NO_ASSERTIONS
    // Fill count never passes the window length
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= len_eff)
        else $error("fill count exceeds window length");

    // Ring pointer stays inside the window
    a_wp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (LW+1)'(wp_reg) < (LW+1)'(len_eff))
        else $error("write pointer outside window");

    // A stalled stage 1 transaction keeps its byte
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s2_load) |=> (s1_valid_reg && $stable(s1_byte_reg)))
        else $error("stage 1 lost its transaction while stalled");

    // A rolling byte always comes from a full window
    a_roll_full: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && is_full) |-> (fill_next == len_eff))
        else $error("rolling byte without a full window");
`endif

endmodule
